/* hw/rtl/ookd_pkg.sv */
// ----------------------------------------------------------------------------
// ookd_pkg
// shared widths, register codes, reset values and types of the ook decoder
// ----------------------------------------------------------------------------
package ookd_pkg;

    localparam int unsigned PULSE_W  = 16;
    localparam int unsigned CODE_W   = 24;
    localparam int unsigned WIN_W    = 13;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 5;
    localparam int unsigned REG_IDX_W = 3;

    // default parameter values
    localparam int unsigned FRAME_BITS_DEF      = 24;
    localparam int unsigned WIDTH_SCALE_DEF     = 10;
    localparam int unsigned SECOND_ONE_MIN_DEF  = 20;
    localparam int unsigned SECOND_ONE_MAX_DEF  = 60;
    localparam int unsigned SECOND_ZERO_MIN_DEF = 61;
    localparam int unsigned SECOND_ZERO_MAX_DEF = 120;

    // register indexes (byte address is four times the index)
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_COUNT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SYNC_GAP_MIN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SYNC_HIGH_MIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SYNC_HIGH_MAX  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_ONE_MIN  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_ONE_MAX  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_ZERO_MIN = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_ZERO_MAX = 3'd7;

    // register reset values
    localparam logic [COUNT_W-1:0] RST_REPEAT_COUNT   = 8'd2;
    localparam logic [PULSE_W-1:0] RST_SYNC_GAP_MIN   = 16'd7000;
    localparam logic [WIN_W-1:0]   RST_SYNC_HIGH_MIN  = 13'd20;
    localparam logic [WIN_W-1:0]   RST_SYNC_HIGH_MAX  = 13'd80;
    localparam logic [WIN_W-1:0]   RST_FIRST_ONE_MIN  = 13'd80;
    localparam logic [WIN_W-1:0]   RST_FIRST_ONE_MAX  = 13'd140;
    localparam logic [WIN_W-1:0]   RST_FIRST_ZERO_MIN = 13'd20;
    localparam logic [WIN_W-1:0]   RST_FIRST_ZERO_MAX = 13'd60;

    typedef logic [CODE_W-1:0] t_code;

    typedef struct packed {
        logic [COUNT_W-1:0] repeat_count;
        logic [PULSE_W-1:0] sync_gap_min;
        logic [WIN_W-1:0]   sync_high_min;
        logic [WIN_W-1:0]   sync_high_max;
        logic [WIN_W-1:0]   first_one_min;
        logic [WIN_W-1:0]   first_one_max;
        logic [WIN_W-1:0]   first_zero_min;
        logic [WIN_W-1:0]   first_zero_max;
    } t_cfg;

    // inclusive window test, empty when lo exceeds hi
    function automatic logic in_win(
        input logic [PULSE_W-1:0] v,
        input logic [PULSE_W-1:0] lo,
        input logic [PULSE_W-1:0] hi
    );
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

/* hw/rtl/ookd_pulse_if.sv */
// ----------------------------------------------------------------------------
// ookd_pulse_if
// request channel carrying one measured pulse width
// ----------------------------------------------------------------------------
interface ookd_pulse_if;
    import ookd_pkg::*;

    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] pulse_width;

    modport source (output valid, output pulse_width, input ready);
    modport sink   (input valid, input pulse_width, output ready);
endinterface

/* hw/rtl/ookd_frame_if.sv */
// ----------------------------------------------------------------------------
// ookd_frame_if
// request channel carrying one confirmed frame code
// ----------------------------------------------------------------------------
interface ookd_frame_if;
    import ookd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] frame_code;
    logic              code_changed;

    modport source (output valid, output frame_code, output code_changed, input ready);
    modport sink   (input valid, input frame_code, input code_changed, output ready);
endinterface

/* hw/rtl/ookd_cfg.sv */
// ----------------------------------------------------------------------------
// ookd_cfg
// apb register file holding the decoder windows and the repeat threshold
// ----------------------------------------------------------------------------
module ookd_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ookd_pkg::APB_AW-1:0]  paddr,
    input  logic [ookd_pkg::APB_DW-1:0]  pwdata,
    output logic [ookd_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output ookd_pkg::t_cfg               o_cfg
);
    import ookd_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[APB_AW-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_count   <= RST_REPEAT_COUNT;
            r_cfg.sync_gap_min   <= RST_SYNC_GAP_MIN;
            r_cfg.sync_high_min  <= RST_SYNC_HIGH_MIN;
            r_cfg.sync_high_max  <= RST_SYNC_HIGH_MAX;
            r_cfg.first_one_min  <= RST_FIRST_ONE_MIN;
            r_cfg.first_one_max  <= RST_FIRST_ONE_MAX;
            r_cfg.first_zero_min <= RST_FIRST_ZERO_MIN;
            r_cfg.first_zero_max <= RST_FIRST_ZERO_MAX;
        end else if (w_wr) begin
            case (w_idx)
                REG_REPEAT_COUNT:   r_cfg.repeat_count   <= pwdata[COUNT_W-1:0];
                REG_SYNC_GAP_MIN:   r_cfg.sync_gap_min   <= pwdata[PULSE_W-1:0];
                REG_SYNC_HIGH_MIN:  r_cfg.sync_high_min  <= pwdata[WIN_W-1:0];
                REG_SYNC_HIGH_MAX:  r_cfg.sync_high_max  <= pwdata[WIN_W-1:0];
                REG_FIRST_ONE_MIN:  r_cfg.first_one_min  <= pwdata[WIN_W-1:0];
                REG_FIRST_ONE_MAX:  r_cfg.first_one_max  <= pwdata[WIN_W-1:0];
                REG_FIRST_ZERO_MIN: r_cfg.first_zero_min <= pwdata[WIN_W-1:0];
                REG_FIRST_ZERO_MAX: r_cfg.first_zero_max <= pwdata[WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_REPEAT_COUNT:   prdata = APB_DW'(r_cfg.repeat_count);
            REG_SYNC_GAP_MIN:   prdata = APB_DW'(r_cfg.sync_gap_min);
            REG_SYNC_HIGH_MIN:  prdata = APB_DW'(r_cfg.sync_high_min);
            REG_SYNC_HIGH_MAX:  prdata = APB_DW'(r_cfg.sync_high_max);
            REG_FIRST_ONE_MIN:  prdata = APB_DW'(r_cfg.first_one_min);
            REG_FIRST_ONE_MAX:  prdata = APB_DW'(r_cfg.first_one_max);
            REG_FIRST_ZERO_MIN: prdata = APB_DW'(r_cfg.first_zero_min);
            REG_FIRST_ZERO_MAX: prdata = APB_DW'(r_cfg.first_zero_max);
            default:            prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/ookd_scale.sv */
// ----------------------------------------------------------------------------
// ookd_scale
// input register and reciprocal multiply giving the scaled pulse width
// ----------------------------------------------------------------------------
module ookd_scale #(
    parameter int unsigned WIDTH_SCALE = ookd_pkg::WIDTH_SCALE_DEF,
    parameter int unsigned S_W         = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ookd_pkg::PULSE_W-1:0] i_pulse_width,
    input  logic [ookd_pkg::PULSE_W-1:0] i_gap_min,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [S_W-1:0]               o_scaled,
    output logic                         o_gap
);
    import ookd_pkg::*;

    // exact floor division by a constant: ceil(2^(n+l)/d), shift by n+l
    localparam int unsigned SCALE_L  = $clog2(WIDTH_SCALE);
    localparam int unsigned SCALE_SH = PULSE_W + SCALE_L;
    localparam int unsigned RECIP_W  = PULSE_W + 1;
    localparam int unsigned PROD_W   = PULSE_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << SCALE_SH) + WIDTH_SCALE - 1) / WIDTH_SCALE;

    logic               r_v0;
    logic [PULSE_W-1:0] r_w;
    logic               r_v1;
    logic [S_W-1:0]     r_scaled;
    logic               r_gap;

    logic               w_en1;
    logic [PROD_W-1:0]  w_prod;

    assign w_en1   = !r_v1 || i_ready;
    assign o_ready = !r_v0 || w_en1;
    assign o_valid = r_v1;
    assign o_scaled = r_scaled;
    assign o_gap    = r_gap;

    assign w_prod = PROD_W'(r_w) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v0 <= i_valid;
            end
            if (w_en1) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_w <= i_pulse_width;
        end
        if (w_en1 && r_v0) begin
            r_scaled <= w_prod[SCALE_SH +: S_W];
            r_gap    <= r_w > i_gap_min;
        end
    end

endmodule

/* hw/rtl/ookd_frame.sv */
// ----------------------------------------------------------------------------
// ookd_frame
// pulse classifier, frame assembler, repeat filter and result register
// ----------------------------------------------------------------------------
module ookd_frame #(
    parameter int unsigned FRAME_BITS      = ookd_pkg::FRAME_BITS_DEF,
    parameter int unsigned S_W             = 13,
    parameter int unsigned SECOND_ONE_MIN  = ookd_pkg::SECOND_ONE_MIN_DEF,
    parameter int unsigned SECOND_ONE_MAX  = ookd_pkg::SECOND_ONE_MAX_DEF,
    parameter int unsigned SECOND_ZERO_MIN = ookd_pkg::SECOND_ZERO_MIN_DEF,
    parameter int unsigned SECOND_ZERO_MAX = ookd_pkg::SECOND_ZERO_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ookd_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [S_W-1:0]               i_scaled,
    input  logic                         i_gap,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ookd_pkg::CODE_W-1:0]  o_frame_code,
    output logic                         o_code_changed
);
    import ookd_pkg::*;

    localparam int unsigned BC_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
    localparam int unsigned PAD  = (BYTE_W - (FRAME_BITS % BYTE_W)) % BYTE_W;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SYNC   = 2'd1;
    localparam logic [1:0] PH_FIRST  = 2'd2;
    localparam logic [1:0] PH_SECOND = 2'd3;

    logic [1:0]         r_phase,    n_phase;
    logic [BC_W-1:0]    r_bit_count, n_bit_count;
    logic               r_pending,  n_pending;
    t_code              r_shift,    n_shift;
    t_code              r_cand,     n_cand;
    logic [COUNT_W-1:0] r_match,    n_match;
    t_code              r_reported, n_reported;
    logic               r_out_valid;
    t_code              r_frame_code;
    logic               r_code_changed;

    logic               w_adv;
    logic               w_done;
    logic               w_emit;
    logic               w_changed;
    logic [PULSE_W-1:0] w_s;
    logic               w_sync_ok, w_one1, w_zero1, w_one2, w_zero2;
    t_code              w_pushed;
    t_code              w_code;
    t_code              w_cand;
    logic [COUNT_W-1:0] w_mc;

    assign o_ready = !r_out_valid || i_ready;
    assign w_adv   = i_valid && o_ready;
    assign o_valid        = r_out_valid;
    assign o_frame_code   = r_frame_code;
    assign o_code_changed = r_code_changed;

    assign w_s       = PULSE_W'(i_scaled);
    assign w_sync_ok = in_win(w_s, PULSE_W'(i_cfg.sync_high_min), PULSE_W'(i_cfg.sync_high_max));
    assign w_one1    = in_win(w_s, PULSE_W'(i_cfg.first_one_min), PULSE_W'(i_cfg.first_one_max));
    assign w_zero1   = in_win(w_s, PULSE_W'(i_cfg.first_zero_min),
                              PULSE_W'(i_cfg.first_zero_max));
    assign w_one2    = in_win(w_s, PULSE_W'(SECOND_ONE_MIN), PULSE_W'(SECOND_ONE_MAX));
    assign w_zero2   = in_win(w_s, PULSE_W'(SECOND_ZERO_MIN), PULSE_W'(SECOND_ZERO_MAX));

    // new bit shifted in, then the byte padding
    assign w_pushed = {r_shift[CODE_W-2:0], w_one2};
    assign w_code   = w_pushed << PAD;

    // repeat filter: equal frames count up, others count down
    assign w_cand = (r_match == '0) ? w_code : r_cand;
    assign w_mc   = (w_cand == w_code) ? r_match + 1'b1 : r_match - 1'b1;
    assign w_changed = r_reported != w_cand;

    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_pending   = r_pending;
        n_shift     = r_shift;
        n_cand      = r_cand;
        n_match     = r_match;
        n_reported  = r_reported;
        w_done      = 1'b0;
        w_emit      = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_gap) begin
                    n_phase = PH_SYNC;
                end
            end
            PH_SYNC: begin
                if (w_sync_ok) begin
                    n_phase = PH_FIRST;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_FIRST: begin
                if (w_one1) begin
                    n_pending = 1'b1;
                    n_phase   = PH_SECOND;
                end else if (w_zero1) begin
                    n_pending = 1'b0;
                    n_phase   = PH_SECOND;
                end else begin
                    n_phase     = PH_IDLE;
                    n_bit_count = '0;
                    n_pending   = 1'b0;
                    n_shift     = '0;
                end
            end
            PH_SECOND: begin
                // second pulse must agree with the class of the first
                if ((w_one2 && r_pending) || (!w_one2 && w_zero2 && !r_pending)) begin
                    n_shift = w_pushed;
                    n_phase = PH_FIRST;
                    if (r_bit_count == BC_W'(FRAME_BITS - 1)) begin
                        w_done = 1'b1;
                    end else begin
                        n_bit_count = r_bit_count + 1'b1;
                    end
                end else begin
                    n_phase     = PH_IDLE;
                    n_bit_count = '0;
                    n_pending   = 1'b0;
                    n_shift     = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (w_done) begin
            n_phase     = PH_IDLE;
            n_bit_count = '0;
            n_pending   = 1'b0;
            n_shift     = '0;
            n_cand      = w_cand;
            if (w_mc >= i_cfg.repeat_count) begin
                w_emit     = 1'b1;
                n_match    = '0;
                n_reported = w_cand;
            end else begin
                n_match = w_mc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= '0;
            r_pending   <= 1'b0;
            r_shift     <= '0;
            r_cand      <= '0;
            r_match     <= '0;
            r_reported  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_phase     <= n_phase;
                r_bit_count <= n_bit_count;
                r_pending   <= n_pending;
                r_shift     <= n_shift;
                r_cand      <= n_cand;
                r_match     <= n_match;
                r_reported  <= n_reported;
            end
            if (w_adv && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_frame_code   <= w_cand;
            r_code_changed <= w_changed;
        end
    end

`ifndef ASSERT_OFF
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_bit_count == '0 && r_shift == '0 && !r_pending)
        else $error("idle phase holds frame residue");

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= BC_W'(FRAME_BITS - 1))
        else $error("bit count beyond frame length");

    a_emit_clears_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_emit |=> r_match == '0 && r_out_valid && r_frame_code == r_reported)
        else $error("report did not clear the repeat filter");

    a_changed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_emit |=> r_code_changed == (r_frame_code != $past(r_reported)))
        else $error("changed flag disagrees with previous report");
`endif

endmodule

/* hw/rtl/ook_pulse_width_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// ook_pulse_width_frame_decoder_core
// ook pulse-width frame decoder with repeat filter and apb configuration
// ----------------------------------------------------------------------------
// one pulse width request is taken every clock cycle unless the pipeline is
// stalled; each passes an input register, a reciprocal multiply that scales it
// (a single 16 x 17 bit multiplier, registered), and the classifier and repeat
// filter that update the frame state and load the result register with the
// report of each confirmed frame. the result register frees the pipeline as
// soon as the sink takes the report, and the input side keeps taking pulses
// until all three stages are full. a wide gap arms the decoder, a sync pulse
// in its window starts a frame and each bit is a pair of pulses whose classes
// must agree; a miss drops the frame. no memories, so there is no clearing
// pass after reset. the user must write registers over apb only while no
// pulse is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module ook_pulse_width_frame_decoder_core #(
    parameter int unsigned FRAME_BITS      = ookd_pkg::FRAME_BITS_DEF,
    parameter int unsigned WIDTH_SCALE     = ookd_pkg::WIDTH_SCALE_DEF,
    parameter int unsigned SECOND_ONE_MIN  = ookd_pkg::SECOND_ONE_MIN_DEF,
    parameter int unsigned SECOND_ONE_MAX  = ookd_pkg::SECOND_ONE_MAX_DEF,
    parameter int unsigned SECOND_ZERO_MIN = ookd_pkg::SECOND_ZERO_MIN_DEF,
    parameter int unsigned SECOND_ZERO_MAX = ookd_pkg::SECOND_ZERO_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ookd_pulse_if.sink                  i_pulse,
    ookd_frame_if.source                o_frame,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ookd_pkg::APB_AW-1:0] paddr,
    input  logic [ookd_pkg::APB_DW-1:0] pwdata,
    output logic [ookd_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import ookd_pkg::*;

    // width of the scaled pulse: largest raw width over the scale factor
    localparam int unsigned S_W = $clog2(((2 ** PULSE_W) - 1) / WIDTH_SCALE + 1);

    t_cfg           w_cfg;
    logic           w_sc_valid;
    logic           w_sc_ready;
    logic [S_W-1:0] w_scaled;
    logic           w_gap;

    // configuration registers
    ookd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input register and scaling by the width factor
    ookd_scale #(
        .WIDTH_SCALE (WIDTH_SCALE),
        .S_W         (S_W)
    ) u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_pulse.valid),
        .o_ready       (i_pulse.ready),
        .i_pulse_width (i_pulse.pulse_width),
        .i_gap_min     (w_cfg.sync_gap_min),
        .o_valid       (w_sc_valid),
        .i_ready       (w_sc_ready),
        .o_scaled      (w_scaled),
        .o_gap         (w_gap)
    );

    // classification, frame assembly, repeat filter, result register
    ookd_frame #(
        .FRAME_BITS      (FRAME_BITS),
        .S_W             (S_W),
        .SECOND_ONE_MIN  (SECOND_ONE_MIN),
        .SECOND_ONE_MAX  (SECOND_ONE_MAX),
        .SECOND_ZERO_MIN (SECOND_ZERO_MIN),
        .SECOND_ZERO_MAX (SECOND_ZERO_MAX)
    ) u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_valid        (w_sc_valid),
        .o_ready        (w_sc_ready),
        .i_scaled       (w_scaled),
        .i_gap          (w_gap),
        .o_valid        (o_frame.valid),
        .i_ready        (o_frame.ready),
        .o_frame_code   (o_frame.frame_code),
        .o_code_changed (o_frame.code_changed)
    );

endmodule

/* dv/ook_pulse_width_frame_decoder_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ook_pulse_width_frame_decoder_core_test
// self-checking bench for the ook pulse-width frame decoder: pulse requests are
// fed from a backlog, each accepted pulse runs through a local decoder model,
// and every frame report is checked in order against the reports it predicts
// ----------------------------------------------------------------------------
module ook_pulse_width_frame_decoder_core_test;
    import ookd_pkg::*;

    // pipeline is three deep; the flush at the end of settle empties anything in flight
    localparam int unsigned FLUSH_CYCLES = 8;
    localparam int unsigned SETTLE_LIMIT = 20000;
    localparam int unsigned BACKLOG_MAX  = 200;

    typedef enum logic [1:0] {
        WAIT_GAP,
        WAIT_SYNC,
        WAIT_FIRST,
        WAIT_SECOND
    } t_rx_phase;

    typedef struct {
        t_code code;
        logic  changed;
    } t_report;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // apb side
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ookd_pulse_if pulse_ch ();
    ookd_frame_if frame_ch ();

    // pulse widths waiting to be offered, and reports the model still owes
    logic [PULSE_W-1:0] pulse_backlog[$];
    t_report            reports_due[$];

    // local copy of the registers and of the decoder state
    t_cfg        regs_model;
    t_rx_phase   rx_phase;
    int unsigned rx_bits;
    logic        rx_pending;
    t_code       rx_shift;
    t_code       cand_code;
    t_code       last_code;
    logic [7:0]  match_cnt;

    int unsigned pulses_taken      = 0;
    int unsigned reports_predicted = 0;
    int unsigned reports_checked   = 0;
    int unsigned settings_used     = 0;
    int unsigned mismatches        = 0;

    // set for one whole phase: neither side idles then
    bit calm = 1'b0;

    ook_pulse_width_frame_decoder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pulse (pulse_ch),
        .o_frame (frame_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------

    // inclusive window, never hit when lo is above hi
    function automatic bit fits(input int unsigned v, input int unsigned lo,
                                input int unsigned hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic void abandon_frame();
        rx_phase   = WAIT_GAP;
        rx_bits    = 0;
        rx_pending = 1'b0;
        rx_shift   = '0;
    endfunction

    // advance the model by one pulse; returns 1 when a report is due
    function automatic bit decode_pulse(input logic [PULSE_W-1:0] w,
                                        output t_code code_o,
                                        output logic changed_o);
        int unsigned s;
        int unsigned pad;
        t_code       fcode;
        logic        bitv;
        bit          ok;
        s         = w / WIDTH_SCALE_DEF;
        code_o    = '0;
        changed_o = 1'b0;
        bitv      = 1'b0;
        ok        = 1'b0;
        case (rx_phase)
            WAIT_GAP: begin
                // raw width, not scaled
                if (w > regs_model.sync_gap_min) rx_phase = WAIT_SYNC;
                return 1'b0;
            end
            WAIT_SYNC: begin
                if (fits(s, regs_model.sync_high_min, regs_model.sync_high_max))
                    rx_phase = WAIT_FIRST;
                else
                    abandon_frame();
                return 1'b0;
            end
            WAIT_FIRST: begin
                // the one window wins where the windows overlap
                if (fits(s, regs_model.first_one_min, regs_model.first_one_max)) begin
                    rx_pending = 1'b1;
                    rx_phase   = WAIT_SECOND;
                end else if (fits(s, regs_model.first_zero_min,
                                  regs_model.first_zero_max)) begin
                    rx_pending = 1'b0;
                    rx_phase   = WAIT_SECOND;
                end else begin
                    abandon_frame();
                end
                return 1'b0;
            end
            default: begin
                if (fits(s, SECOND_ONE_MIN_DEF, SECOND_ONE_MAX_DEF)) begin
                    bitv = 1'b1;
                    ok   = rx_pending;
                end else if (fits(s, SECOND_ZERO_MIN_DEF, SECOND_ZERO_MAX_DEF)) begin
                    bitv = 1'b0;
                    ok   = !rx_pending;
                end
                if (!ok) begin
                    abandon_frame();
                    return 1'b0;
                end
                rx_shift = {rx_shift[CODE_W-2:0], bitv};
                rx_phase = WAIT_FIRST;
                rx_bits++;
                if (rx_bits < FRAME_BITS_DEF) return 1'b0;
            end
        endcase

        // frame complete: pad to whole bytes, older bits fall off the top
        pad = (BYTE_W - (FRAME_BITS_DEF % BYTE_W)) % BYTE_W;
        for (int k = 0; k < pad; k++) rx_shift = {rx_shift[CODE_W-2:0], 1'b0};
        fcode = rx_shift;
        abandon_frame();

        // repeat filter: equal frames count up, others count down
        if (match_cnt == 0) cand_code = fcode;
        if (cand_code == fcode)
            match_cnt = match_cnt + 8'd1;
        else
            match_cnt = match_cnt - 8'd1;
        if (match_cnt < regs_model.repeat_count) return 1'b0;
        match_cnt = '0;
        changed_o = (last_code != cand_code);
        last_code = cand_code;
        code_o    = last_code;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // pulse driver: offers the backlog, predicts on every accepted request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : pulse_driver
        t_code pcode;
        logic  pchanged;
        if (!i_rst_n) begin
            pulse_ch.valid <= 1'b0;
        end else begin
            if (pulse_ch.valid && pulse_ch.ready) begin
                pulses_taken++;
                if (decode_pulse(pulse_ch.pulse_width, pcode, pchanged)) begin
                    reports_due.push_back('{code: pcode, changed: pchanged});
                    reports_predicted++;
                end
            end
            // a held request stays put until taken
            if (!pulse_ch.valid || pulse_ch.ready) begin
                if (pulse_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
                    pulse_ch.valid       <= 1'b1;
                    pulse_ch.pulse_width <= pulse_backlog.pop_front();
                end else begin
                    pulse_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // frame monitor: checks each taken report against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : frame_monitor
        t_report want;
        if (!i_rst_n) begin
            frame_ch.ready <= 1'b0;
        end else begin
            if (frame_ch.valid && frame_ch.ready) begin
                reports_checked++;
                if (reports_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected report code=%06h changed=%0b",
                                 $realtime, frame_ch.frame_code, frame_ch.code_changed);
                    mismatches++;
                end else begin
                    want = reports_due.pop_front();
                    if (frame_ch.frame_code !== want.code ||
                        frame_ch.code_changed !== want.changed) begin
                        if (mismatches < 10)
                            $display("%0t: expected %06h/%0b, got %06h/%0b",
                                     $realtime, want.code, want.changed,
                                     frame_ch.frame_code, frame_ch.code_changed);
                        mismatches++;
                    end
                end
            end
            frame_ch.ready <= calm || ($urandom_range(0, 99) >= 22);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one apb write: setup cycle, then access until pready
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // the register takes the value at this edge
        case (idx)
            REG_REPEAT_COUNT:   regs_model.repeat_count   = data[COUNT_W-1:0];
            REG_SYNC_GAP_MIN:   regs_model.sync_gap_min   = data[PULSE_W-1:0];
            REG_SYNC_HIGH_MIN:  regs_model.sync_high_min  = data[WIN_W-1:0];
            REG_SYNC_HIGH_MAX:  regs_model.sync_high_max  = data[WIN_W-1:0];
            REG_FIRST_ONE_MIN:  regs_model.first_one_min  = data[WIN_W-1:0];
            REG_FIRST_ONE_MAX:  regs_model.first_one_max  = data[WIN_W-1:0];
            REG_FIRST_ZERO_MIN: regs_model.first_zero_min = data[WIN_W-1:0];
            REG_FIRST_ZERO_MAX: regs_model.first_zero_max = data[WIN_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_regs(input t_cfg c);
        apb_write(REG_REPEAT_COUNT,   32'(c.repeat_count));
        apb_write(REG_SYNC_GAP_MIN,   32'(c.sync_gap_min));
        apb_write(REG_SYNC_HIGH_MIN,  32'(c.sync_high_min));
        apb_write(REG_SYNC_HIGH_MAX,  32'(c.sync_high_max));
        apb_write(REG_FIRST_ONE_MIN,  32'(c.first_one_min));
        apb_write(REG_FIRST_ONE_MAX,  32'(c.first_one_max));
        apb_write(REG_FIRST_ZERO_MIN, 32'(c.first_zero_min));
        apb_write(REG_FIRST_ZERO_MAX, 32'(c.first_zero_max));
        settings_used++;
    endtask

    // sender drains, every report arrives, then the pipeline is flushed
    task automatic settle();
        int unsigned waited;
        waited = 0;
        while ((pulse_backlog.size() != 0 || pulse_ch.valid || reports_due.size() != 0)
               && waited < SETTLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    // a width whose scaled value lands in [lo, hi], edges favoured
    function automatic logic [PULSE_W-1:0] width_for(input int unsigned lo,
                                                    input int unsigned hi);
        int unsigned s;
        int unsigned w;
        if (lo > hi) return PULSE_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 5))
            0:       s = lo;
            1:       s = hi;
            default: s = $urandom_range(lo, hi);
        endcase
        w = s * WIDTH_SCALE_DEF + $urandom_range(0, WIDTH_SCALE_DEF - 1);
        if (w > 65535) w = 65535;
        return w[PULSE_W-1:0];
    endfunction

    // gap, sync and one pulse pair per bit; a spoilt frame gets one pulse
    // overwritten with noise or loses its tail
    task automatic queue_frame(input t_code code, input bit spoil, output int unsigned n);
        logic [PULSE_W-1:0] seq[$];
        logic [PULSE_W-1:0] w;
        int unsigned        cut;
        bit                 one_cls;
        while (pulse_backlog.size() > BACKLOG_MAX) @(posedge i_clk);
        if (regs_model.sync_gap_min == 16'hFFFF)
            seq.push_back(16'hFFFF);
        else if ($urandom_range(0, 3) == 0)
            seq.push_back(regs_model.sync_gap_min + 16'd1);
        else
            seq.push_back(PULSE_W'($urandom_range(regs_model.sync_gap_min + 1, 65535)));
        seq.push_back(width_for(regs_model.sync_high_min, regs_model.sync_high_max));
        for (int i = FRAME_BITS_DEF - 1; i >= 0; i--) begin
            // an empty zero window forces the one window
            if ((code[i] && regs_model.first_one_min <= regs_model.first_one_max) ||
                regs_model.first_zero_min > regs_model.first_zero_max)
                w = width_for(regs_model.first_one_min, regs_model.first_one_max);
            else
                w = width_for(regs_model.first_zero_min, regs_model.first_zero_max);
            seq.push_back(w);
            // second pulse follows the class the first one really falls in
            one_cls = fits(w / WIDTH_SCALE_DEF, regs_model.first_one_min,
                           regs_model.first_one_max) ||
                      !fits(w / WIDTH_SCALE_DEF, regs_model.first_zero_min,
                            regs_model.first_zero_max);
            seq.push_back(one_cls ? width_for(SECOND_ONE_MIN_DEF, SECOND_ONE_MAX_DEF)
                                  : width_for(SECOND_ZERO_MIN_DEF, SECOND_ZERO_MAX_DEF));
        end
        if (spoil) begin
            cut = $urandom_range(0, seq.size() - 1);
            if ($urandom_range(0, 1) == 0)
                seq[cut] = PULSE_W'($urandom_range(0, 65535));
            else
                while (seq.size() > cut) void'(seq.pop_back());
        end
        n = seq.size();
        foreach (seq[k]) pulse_backlog.push_back(seq[k]);
    endtask

    // one register setting: mostly good frames around a favourite code,
    // some spoilt frames and some loose noise, with one full drain midway
    task automatic run_phase(input t_cfg c, input int unsigned n_items,
                             input int unsigned min_reports);
        int unsigned pushed;
        int unsigned base;
        int unsigned n;
        int unsigned pick;
        bit          paused;
        t_code       favourite;
        program_regs(c);
        pushed    = 0;
        paused    = 1'b0;
        base      = reports_predicted;
        favourite = t_code'($urandom());
        while ((pushed < n_items || reports_predicted - base < min_reports) &&
               pushed < 40 * n_items + 2000) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                if ($urandom_range(0, 9) == 0) favourite = t_code'($urandom());
                queue_frame(($urandom_range(0, 99) < 70) ? favourite : t_code'($urandom()),
                            1'b0, n);
            end else if (pick < 87) begin
                queue_frame(favourite, 1'b1, n);
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) pulse_backlog.push_back(PULSE_W'($urandom_range(0, 65535)));
            end
            pushed += n;
            if (!paused && pushed >= n_items / 2) begin
                paused = 1'b1;
                settle();
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        pulse_ch.valid       = 1'b0;
        pulse_ch.pulse_width = '0;
        frame_ch.ready       = 1'b0;

        // model starts from the reset state
        regs_model = '{repeat_count:   RST_REPEAT_COUNT,
                       sync_gap_min:   RST_SYNC_GAP_MIN,
                       sync_high_min:  RST_SYNC_HIGH_MIN,
                       sync_high_max:  RST_SYNC_HIGH_MAX,
                       first_one_min:  RST_FIRST_ONE_MIN,
                       first_one_max:  RST_FIRST_ONE_MAX,
                       first_zero_min: RST_FIRST_ZERO_MIN,
                       first_zero_max: RST_FIRST_ZERO_MAX};
        abandon_frame();
        cand_code = '0;
        last_code = '0;
        match_cnt = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk at reset settings: width extremes, gap at the
        // threshold, window edges, a wide miss that must not re-arm,
        // second pulse off by one and a class disagreement
        pulse_backlog = '{16'd0, 16'd65535, 16'd65535, 16'd7000, 16'd7001, 16'd200,
                          16'd800, 16'd600, 16'd609, 16'd610, 16'd200, 16'd1209,
                          16'd1409, 16'd199, 16'd9999, 16'd809, 16'd819, 16'd1210,
                          16'd65535, 16'd500, 16'd1000, 16'd700, 16'd7001, 16'd199,
                          16'd19};
        settle();

        // reset settings again, written explicitly
        run_phase('{8'd2, 16'd7000, 13'd20, 13'd80, 13'd80, 13'd140, 13'd20, 13'd60},
                  250, 2);

        // overlapping first windows, widest sync window, no idling anywhere
        calm = 1'b1;
        run_phase('{8'd1, 16'd3000, 13'd0, 13'd6553, 13'd30, 13'd100, 13'd20, 13'd60},
                  250, 4);
        calm = 1'b0;

        // repeat count zero, any non-zero width arms, first windows at extremes
        run_phase('{8'd0, 16'd0, 13'd40, 13'd40, 13'd100, 13'd6553, 13'd0, 13'd99},
                  200, 3);

        // empty zero window, only the widest pulses arm
        run_phase('{8'd3, 16'd65534, 13'd10, 13'd50, 13'd90, 13'd130, 13'd100, 13'd50},
                  200, 1);

        // nothing can arm; empty sync window
        run_phase('{8'd2, 16'd65535, 13'd6553, 13'd0, 13'd0, 13'd0, 13'd6553, 13'd6553},
                  40, 0);

        // highest repeat count: the filter only accumulates
        run_phase('{8'd255, 16'd100, 13'd20, 13'd80, 13'd80, 13'd140, 13'd20, 13'd60},
                  200, 0);

        // every good frame reports
        run_phase('{8'd1, 16'd7000, 13'd20, 13'd80, 13'd70, 13'd140, 13'd20, 13'd75},
                  150, 3);

        settle();
        mismatches += reports_due.size();

        $display("run covered %0d pulse requests over %0d register settings",
                 pulses_taken, settings_used);
        $display("%0d frame reports checked, %0d predicted", reports_checked,
                 reports_predicted);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
